// ----- rtl/core/pseudo3d_road_point_generator_assert.svh -----
// Assertion macros for the road point generator.
`ifndef PSEUDO3D_ROAD_POINT_GENERATOR_ASSERT_SVH
`define PSEUDO3D_ROAD_POINT_GENERATOR_ASSERT_SVH

// Check a condition at every clock edge outside reset.
`define P3DRPG_ASSERT_NOW(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("road point generator: invariant violated");

// Check that a condition implies another in the next cycle.
`define P3DRPG_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("road point generator: sequence violated");

`endif

// ----- rtl/core/p3drpg_pkg.sv -----
`timescale 1ns / 1ps

package p3drpg_pkg;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_TICK  = 1'b1;

  localparam logic [1:0] CFG_SEGMENT_LENGTH = 2'd0;
  localparam logic [1:0] CFG_SPEED          = 2'd1;
  localparam logic [1:0] CFG_SEG_COUNT      = 2'd2;
  localparam logic [1:0] CFG_ROAD_HEIGHT    = 2'd3;

  typedef struct packed {
    logic wr;
    logic start;
    logic mod_step;
    logic rd_setup;
    logic mul1;
    logic mul2;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic mod_done;
    logic run_last;
    logic out_free;
  } status_t;

endpackage

// ----- rtl/core/p3drpg_ram.sv -----
`timescale 1ns / 1ps

module p3drpg_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/p3drpg_ctrl.sv -----
`timescale 1ns / 1ps

module p3drpg_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                func,
  output logic                in_stall,
  input  p3drpg_pkg::status_t status,
  output p3drpg_pkg::cmd_t    cmd
);

  typedef enum logic [2:0] {
    IDLE,
    MOD,
    READ,
    MUL1,
    MUL2,
    RUN
  } state_t;

  state_t state;

  assign in_stall = (state != IDLE);

  always_comb begin
    cmd = '0;
    case (state)
      IDLE: begin
        cmd.wr    = in_valid && (func == p3drpg_pkg::FUNC_WRITE);
        cmd.start = in_valid && (func == p3drpg_pkg::FUNC_TICK);
      end
      MOD:  cmd.mod_step = 1'b1;
      READ: cmd.rd_setup = 1'b1;
      MUL1: cmd.mul1     = 1'b1;
      MUL2: cmd.mul2     = 1'b1;
      RUN:  cmd.emit     = status.out_free;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      case (state)
        IDLE: begin
          if (in_valid && (func == p3drpg_pkg::FUNC_TICK)) begin
            state <= MOD;
          end
        end
        MOD: begin
          if (status.mod_done) begin
            state <= READ;
          end
        end
        READ: state <= MUL1;
        MUL1: state <= MUL2;
        MUL2: state <= RUN;
        RUN: begin
          if (status.out_free && status.run_last) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/core/p3drpg_dpath.sv -----
`timescale 1ns / 1ps

module p3drpg_dpath #(
  parameter int SEG_MAX     = 512,
  parameter int VIEW_POINTS = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  p3drpg_pkg::cmd_t           cmd,
  output p3drpg_pkg::status_t        status,
  input  logic [8:0]                 seg_index,
  input  logic signed [11:0]         seg_curve,
  input  logic signed [11:0]         seg_pitch,
  input  logic                       cfg_write,
  input  logic [1:0]                 cfg_index,
  input  logic [15:0]                cfg_data,
  input  logic                       out_stall,
  output logic                       out_valid,
  output logic signed [31:0]         point_x,
  output logic signed [31:0]         point_y,
  output logic signed [31:0]         point_z,
  output logic                       last_point
);

  localparam int IW  = $clog2(SEG_MAX);
  localparam int NW  = $clog2(SEG_MAX + 1);
  localparam int CW  = IW + 8;
  localparam int SW  = ((CW > 12) ? CW : 12) + 1;
  localparam int QW  = SW - 8;
  localparam int SBW = $clog2(QW);
  localparam int MW  = QW + NW;
  localparam int KW  = (VIEW_POINTS > 1) ? $clog2(VIEW_POINTS) : 1;
  localparam int AIW = (IW > 9) ? IW : 9;
  localparam int AW  = 48;

  localparam logic signed [AW-1:0] SAT_MAX = {{(AW - 31){1'b0}}, {31{1'b1}}};
  localparam logic signed [AW-1:0] SAT_MIN = {{(AW - 31){1'b1}}, {31{1'b0}}};

  function automatic logic signed [31:0] sat32(input logic signed [AW-1:0] v);
    logic signed [31:0] r;
    if (v > SAT_MAX) begin
      r = SAT_MAX[31:0];
    end else if (v < SAT_MIN) begin
      r = SAT_MIN[31:0];
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  logic [15:0]        segment_length;
  logic [11:0]        speed;
  logic [9:0]         seg_count;
  logic signed [15:0] road_height;

  logic [NW-1:0]  n;
  logic [CW-1:0]  camera_pos;
  logic [SW-1:0]  pos_sum;
  logic [QW-1:0]  rem;
  logic [QW-1:0]  rem_sub;
  logic [7:0]     frac;
  logic [SBW-1:0] sstep;
  logic [MW-1:0]  nsh;

  logic [IW-1:0]  seg_ptr;
  logic [IW-1:0]  seg_next;
  logic [AIW-1:0] seg_wide;

  logic           ram_we;
  logic           ram_re;
  logic [IW-1:0]  ram_raddr;
  logic [23:0]    ram_rdata;
  logic signed [11:0] rd_c;
  logic signed [11:0] rd_p;

  logic signed [20:0] fc;
  logic signed [20:0] fp;
  logic [15:0]        ff;
  logic [23:0]        fl;
  logic signed [28:0] prod_cx;
  logic signed [28:0] prod_cy;

  logic signed [AW-1:0] cx;
  logic signed [AW-1:0] cy;
  logic signed [AW-1:0] cz;
  logic signed [AW-1:0] xd;
  logic signed [AW-1:0] yd;
  logic signed [AW-1:0] zd;
  logic [KW-1:0]        k;

  always_ff @(posedge clk) begin
    if (rst) begin
      segment_length <= 16'd1280;
      speed          <= 12'd26;
      seg_count      <= 10'd195;
      road_height    <= -16'sd2560;
    end else if (cfg_write) begin
      case (cfg_index)
        p3drpg_pkg::CFG_SEGMENT_LENGTH: segment_length <= cfg_data;
        p3drpg_pkg::CFG_SPEED:          speed          <= cfg_data[11:0];
        p3drpg_pkg::CFG_SEG_COUNT:      seg_count      <= cfg_data[9:0];
        p3drpg_pkg::CFG_ROAD_HEIGHT:    road_height    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (seg_count == '0) begin
      n = NW'(1);
    end else if (32'(seg_count) > SEG_MAX) begin
      n = NW'(SEG_MAX);
    end else begin
      n = NW'(seg_count);
    end
  end

  assign pos_sum = SW'(camera_pos) + SW'(speed);
  assign nsh     = MW'(n) << sstep;
  assign rem_sub = (MW'(rem) >= nsh) ? (rem - QW'(nsh)) : rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      camera_pos <= '0;
    end else if (cmd.mod_step && (sstep == '0)) begin
      camera_pos <= {rem_sub[IW-1:0], frac};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rem   <= pos_sum[SW-1:8];
      frac  <= pos_sum[7:0];
      sstep <= SBW'(QW - 1);
    end else if (cmd.mod_step) begin
      rem   <= rem_sub;
      sstep <= sstep - SBW'(1);
    end
  end

  assign seg_wide  = AIW'(seg_index);
  assign ram_we    = cmd.wr && (32'(seg_index) < SEG_MAX);
  assign seg_next  = ((NW'(seg_ptr) + NW'(1)) == n) ? '0 : (seg_ptr + IW'(1));
  assign ram_re    = cmd.rd_setup || cmd.emit;
  assign ram_raddr = cmd.rd_setup ? camera_pos[CW-1:8] : seg_next;

  p3drpg_ram #(
    .WIDTH(24),
    .DEPTH(SEG_MAX)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(seg_wide[IW-1:0]),
    .wdata({seg_curve, seg_pitch}),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign rd_c = ram_rdata[23:12];
  assign rd_p = ram_rdata[11:0];

  assign prod_cx = $signed({1'b0, ff}) * rd_c;
  assign prod_cy = $signed({1'b0, ff}) * rd_p;

  always_ff @(posedge clk) begin
    if (cmd.rd_setup) begin
      seg_ptr <= camera_pos[CW-1:8];
    end else if (cmd.emit) begin
      seg_ptr <= seg_next;
    end
    if (cmd.mul1) begin
      fc <= $signed({1'b0, camera_pos[7:0]}) * rd_c;
      fp <= $signed({1'b0, camera_pos[7:0]}) * rd_p;
      ff <= camera_pos[7:0] * camera_pos[7:0];
      fl <= camera_pos[7:0] * segment_length;
    end
    if (cmd.mul2) begin
      xd <= -(AW'(fc) <<< 8);
      yd <= -(AW'(fp) <<< 8);
      cx <= AW'(prod_cx);
      cy <= AW'(prod_cy);
      cz <= -$signed(AW'(fl));
      zd <= $signed(AW'({segment_length, 8'h00}));
      k  <= '0;
    end else if (cmd.emit) begin
      cx <= cx + xd;
      cy <= cy + yd;
      cz <= cz + zd;
      xd <= xd + (AW'(rd_c) <<< 16);
      yd <= yd + (AW'(rd_p) <<< 16);
      k  <= k + KW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      point_x    <= sat32(cx >>> 16);
      point_y    <= sat32((cy >>> 16) + AW'(road_height));
      point_z    <= sat32(cz >>> 8);
      last_point <= status.run_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.emit || (out_valid && out_stall);
    end
  end

  assign status.mod_done = (sstep == '0);
  assign status.run_last = (k == KW'(VIEW_POINTS - 1));
  assign status.out_free = !out_valid || !out_stall;

endmodule

// ----- rtl/core/pseudo3d_road_point_generator.sv -----
`timescale 1ns / 1ps
// Pseudo-3D road point generator.
// Input channel (in_valid/in_stall): func 0 stores seg_curve/seg_pitch at seg_index;
// func 1 is a frame tick that advances the camera by speed around the course
// and then emits VIEW_POINTS road points on the output channel, last_point set on the
// final one. The block takes no new item until a tick's last point is loaded into the
// output register.
// Sequence: the camera wrap runs an iterative reduction of one quotient bit per cycle,
// followed by a table read and the MUL1 and MUL2 multiply steps. Points then leave one
// per cycle from the accumulators while the output is not stalled; a write does not
// stall the input channel.
// Output channel (out_valid/out_stall): a stall holds the registered point and pauses
// the point walk, one point per cycle resumes when released.
// Configuration: cfg_write/cfg_index/cfg_data; user writes only while idle, unchecked.
// Reset (rst, synchronous) restores register defaults, sets the camera to zero and drops
// any pending points; table entries stay undefined until written.
module pseudo3d_road_point_generator #(
  parameter int SEG_MAX     = 512,
  parameter int VIEW_POINTS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               func,
  input  logic [8:0]         seg_index,
  input  logic signed [11:0] seg_curve,
  input  logic signed [11:0] seg_pitch,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] point_x,
  output logic signed [31:0] point_y,
  output logic signed [31:0] point_z,
  output logic               last_point
);

  p3drpg_pkg::cmd_t    cmd;
  p3drpg_pkg::status_t status;

  p3drpg_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .func    (func),
    .in_stall(in_stall),
    .status  (status),
    .cmd     (cmd)
  );

  p3drpg_dpath #(
    .SEG_MAX    (SEG_MAX),
    .VIEW_POINTS(VIEW_POINTS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .seg_index (seg_index),
    .seg_curve (seg_curve),
    .seg_pitch (seg_pitch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .point_x   (point_x),
    .point_y   (point_y),
    .point_z   (point_z),
    .last_point(last_point)
  );

`include "pseudo3d_road_point_generator_assert.svh"

  `P3DRPG_ASSERT_NOW(a_cmd_onehot, $onehot0(cmd))
  `P3DRPG_ASSERT_NOW(a_emit_busy, !(cmd.emit && !in_stall))
  `P3DRPG_ASSERT_NEXT(a_tick_busy, in_valid && !in_stall && (func == p3drpg_pkg::FUNC_TICK), in_stall)
  `P3DRPG_ASSERT_NEXT(a_last_drains, out_valid && !out_stall && last_point, !out_valid)

endmodule

// ----- test/pseudo3d_road_point_generator_tb.sv -----
`timescale 1ns / 1ps

module pseudo3d_road_point_generator_tb;

  localparam int VIEW_POINTS     = 64;
  localparam int SEG_MAX         = 512;
  localparam int DIR_ROWS        = 25;
  localparam int RAND_PHASES     = 8;
  localparam int ITEMS_PER_PHASE = 55;
  localparam int HOLD_PHASE      = 3;
  localparam int HOLD_CYCLES     = 400;
  localparam int SETTLE_CYCLES   = 20;
  localparam int DRAIN_CYCLES    = 100;
  localparam int CYCLE_LIMIT     = 2000000;

  typedef enum logic [1:0] {
    REG_SEG_LENGTH  = p3drpg_pkg::CFG_SEGMENT_LENGTH,
    REG_SPEED       = p3drpg_pkg::CFG_SPEED,
    REG_SEG_COUNT   = p3drpg_pkg::CFG_SEG_COUNT,
    REG_ROAD_HEIGHT = p3drpg_pkg::CFG_ROAD_HEIGHT
  } cfg_reg_e;

  typedef enum logic [1:0] {ROW_WRITE, ROW_TICK, ROW_FLAT, ROW_REG} row_kind_e;

  typedef struct packed {
    row_kind_e          kind;
    cfg_reg_e           reg_sel;
    logic [8:0]         index;
    logic [15:0]        val;
    logic [11:0]        pitch;
    logic signed [31:0] flat_y;
  } dir_row_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               last;
  } road_point_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               func = 1'b0;
  logic [8:0]         seg_index = '0;
  logic signed [11:0] seg_curve = '0;
  logic signed [11:0] seg_pitch = '0;
  logic               cfg_write = 1'b0;
  logic [1:0]         cfg_index = '0;
  logic [15:0]        cfg_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;
  logic               last_point;

  pseudo3d_road_point_generator u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .func       (func),
    .seg_index  (seg_index),
    .seg_curve  (seg_curve),
    .seg_pitch  (seg_pitch),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .point_x    (point_x),
    .point_y    (point_y),
    .point_z    (point_z),
    .last_point (last_point)
  );

  // shadow of the block
  logic signed [11:0] curve_mem [SEG_MAX];
  logic signed [11:0] pitch_mem [SEG_MAX];
  bit                 written_mem [SEG_MAX];
  int unsigned        cam = 0;
  logic [15:0]        seg_len_reg = 16'd1280;
  logic [11:0]        speed_reg = 12'd26;
  logic [9:0]         seg_count_reg = 10'd195;
  logic signed [15:0] road_height_reg = -16'sd2560;

  road_point_t road_pts [$];
  road_point_t next_point;
  int          errors = 0;
  int          points_seen = 0;
  int          items_sent = 0;
  int          cycles = 0;
  int          stall_left = 0;
  int          hold_left = 0;
  bit          hold_req = 1'b0;
  bit          hold_done = 1'b0;
  bit          quiet = 1'b0;

  dir_row_t dir_table [DIR_ROWS] = '{
    '{ROW_WRITE, REG_SEG_LENGTH,  9'd0,   16'h0000, 12'h000, 32'sd0},
    '{ROW_WRITE, REG_SEG_LENGTH,  9'd1,   16'h0000, 12'h000, 32'sd0},
    '{ROW_WRITE, REG_SEG_LENGTH,  9'd2,   16'h0000, 12'h000, 32'sd0},
    '{ROW_WRITE, REG_SEG_LENGTH,  9'd3,   16'h0000, 12'h000, 32'sd0},
    '{ROW_REG,   REG_SEG_COUNT,   9'd0,   16'd4,    12'h000, 32'sd0},
    '{ROW_REG,   REG_SPEED,       9'd0,   16'd256,  12'h000, 32'sd0},
    '{ROW_REG,   REG_SEG_LENGTH,  9'd0,   16'h0000, 12'h000, 32'sd0},
    '{ROW_REG,   REG_ROAD_HEIGHT, 9'd0,   16'h8000, 12'h000, 32'sd0},
    '{ROW_FLAT,  REG_SEG_LENGTH,  9'd0,   16'h0000, 12'h000, -32'sd32768},
    '{ROW_REG,   REG_ROAD_HEIGHT, 9'd0,   16'h7FFF, 12'h000, 32'sd0},
    '{ROW_FLAT,  REG_SEG_LENGTH,  9'd0,   16'h0000, 12'h000, 32'sd32767},
    '{ROW_REG,   REG_SEG_LENGTH,  9'd0,   16'hFFFF, 12'h000, 32'sd0},
    '{ROW_TICK,  REG_SEG_LENGTH,  9'd0,   16'h0000, 12'h000, 32'sd0},
    '{ROW_WRITE, REG_SEG_LENGTH,  9'd1,   16'h0800, 12'h7FF, 32'sd0},
    '{ROW_WRITE, REG_SEG_LENGTH,  9'd2,   16'h07FF, 12'h800, 32'sd0},
    '{ROW_WRITE, REG_SEG_LENGTH,  9'd3,   16'h0FFF, 12'h001, 32'sd0},
    '{ROW_WRITE, REG_SEG_LENGTH,  9'd511, 16'h07FF, 12'h7FF, 32'sd0},
    '{ROW_REG,   REG_SPEED,       9'd0,   16'h0FFF, 12'h000, 32'sd0},
    '{ROW_TICK,  REG_SEG_LENGTH,  9'd0,   16'h0000, 12'h000, 32'sd0},
    '{ROW_REG,   REG_SPEED,       9'd0,   16'h0081, 12'h000, 32'sd0},
    '{ROW_TICK,  REG_SEG_LENGTH,  9'd0,   16'h0000, 12'h000, 32'sd0},
    '{ROW_TICK,  REG_SEG_LENGTH,  9'd0,   16'h0000, 12'h000, 32'sd0},
    '{ROW_REG,   REG_SEG_COUNT,   9'd0,   16'd0,    12'h000, 32'sd0},
    '{ROW_TICK,  REG_SEG_LENGTH,  9'd0,   16'h0000, 12'h000, 32'sd0},
    '{ROW_TICK,  REG_SEG_LENGTH,  9'd0,   16'h0000, 12'h000, 32'sd0}
  };

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d points pending", cycles, road_pts.size());
      $display("pseudo3d_road_point_generator_tb NOT OK");
      $finish;
    end
  end

  function automatic logic signed [31:0] sat32(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic int unsigned course_segs();
    int unsigned n;
    n = seg_count_reg;
    if (n == 0) n = 1;
    if (n > SEG_MAX) n = SEG_MAX;
    return n;
  endfunction

  function automatic int unsigned next_cam();
    int unsigned total;
    int unsigned p;
    total = course_segs() << 8;
    p = cam % total + speed_reg;
    if (p >= total) p -= total;
    if (p >= total) p %= total;
    return p;
  endfunction

  task automatic predict_road(logic fn, logic [8:0] ix, logic signed [11:0] cv,
                              logic signed [11:0] pv, bit emit);
    int unsigned n;
    int unsigned first;
    int unsigned i;
    longint      f;
    longint      len;
    longint      xd;
    longint      yd;
    longint      cx;
    longint      cy;
    longint      cz;
    longint      zd;
    road_point_t p;
    if (fn == p3drpg_pkg::FUNC_WRITE) begin
      curve_mem[ix]   = cv;
      pitch_mem[ix]   = pv;
      written_mem[ix] = 1'b1;
    end else begin
      n     = course_segs();
      cam   = next_cam();
      first = cam >> 8;
      f     = cam & 32'hFF;
      len   = seg_len_reg;
      xd    = -f * longint'(curve_mem[first]) * 256;
      yd    = -f * longint'(pitch_mem[first]) * 256;
      cx    = f * f * longint'(curve_mem[first]);
      cy    = f * f * longint'(pitch_mem[first]);
      cz    = -f * len;
      zd    = len * 256;
      for (int k = 0; k < VIEW_POINTS; k++) begin
        p.x    = sat32(cx >>> 16);
        p.y    = sat32((cy >>> 16) + longint'(road_height_reg));
        p.z    = sat32(cz >>> 8);
        p.last = (k == VIEW_POINTS - 1);
        if (emit) road_pts.push_back(p);
        cx += xd;
        cy += yd;
        cz += zd;
        i = (first + k) % n;
        xd += longint'(curve_mem[i]) * 65536;
        yd += longint'(pitch_mem[i]) * 65536;
      end
    end
  endtask

  task automatic report_mismatch(string msg);
    $display("ERROR point %0d: %s", points_seen, msg);
    errors++;
  endtask

  task automatic send_item(logic fn, logic [8:0] ix, logic [11:0] cv, logic [11:0] pv,
                           bit flat, logic signed [31:0] flat_y);
    int          gap;
    road_point_t p;
    if (!quiet && $urandom_range(3) == 0) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    func      <= fn;
    seg_index <= ix;
    seg_curve <= cv;
    seg_pitch <= pv;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    predict_road(fn, ix, cv, pv, !flat);
    if (fn == p3drpg_pkg::FUNC_TICK && flat) begin
      for (int k = 0; k < VIEW_POINTS; k++) begin
        p.x    = 32'sd0;
        p.y    = flat_y;
        p.z    = 32'sd0;
        p.last = (k == VIEW_POINTS - 1);
        road_pts.push_back(p);
      end
    end
  endtask

  // write every unwritten entry that the next tick will read, then send the tick
  task automatic send_tick(bit flat, logic signed [31:0] flat_y);
    int unsigned n;
    int unsigned first;
    int unsigned j;
    n     = course_segs();
    first = next_cam() >> 8;
    for (int k = 0; k < VIEW_POINTS; k++) begin
      j = (first + k) % n;
      if (!written_mem[j])
        send_item(p3drpg_pkg::FUNC_WRITE, 9'(j), 12'($urandom), 12'($urandom),
                  1'b0, 32'sd0);
    end
    send_item(p3drpg_pkg::FUNC_TICK, 9'($urandom), 12'($urandom), 12'($urandom),
              flat, flat_y);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (road_pts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_e r, logic [15:0] v);
    settle();
    cfg_write <= 1'b1;
    cfg_index <= r;
    cfg_data  <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
    case (r)
      REG_SEG_LENGTH:  seg_len_reg = v;
      REG_SPEED:       speed_reg = v[11:0];
      REG_SEG_COUNT:   seg_count_reg = v[9:0];
      REG_ROAD_HEIGHT: road_height_reg = v;
      default: ;
    endcase
  endtask

  // output side: check each accepted point and pick the next stall
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (road_pts.size() == 0) begin
          report_mismatch($sformatf("unexpected point x=%0d y=%0d z=%0d last=%0d",
                                    point_x, point_y, point_z, last_point));
        end else begin
          next_point = road_pts.pop_front();
          if (point_x !== next_point.x)
            report_mismatch($sformatf("point_x %0d, want %0d", point_x, next_point.x));
          if (point_y !== next_point.y)
            report_mismatch($sformatf("point_y %0d, want %0d", point_y, next_point.y));
          if (point_z !== next_point.z)
            report_mismatch($sformatf("point_z %0d, want %0d", point_z, next_point.z));
          if (last_point !== next_point.last)
            report_mismatch($sformatf("last_point %0b, want %0b", last_point,
                                      next_point.last));
        end
        points_seen++;
      end
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(5) == 0) begin
        stall_left = $urandom_range(1, 6) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    dir_row_t row;
    int       phase_end;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int r = 0; r < DIR_ROWS; r++) begin
      row = dir_table[r];
      case (row.kind)
        ROW_WRITE: send_item(p3drpg_pkg::FUNC_WRITE, row.index, row.val[11:0], row.pitch,
                             1'b0, 32'sd0);
        ROW_TICK:  send_tick(1'b0, 32'sd0);
        ROW_FLAT:  send_tick(1'b1, row.flat_y);
        ROW_REG:   write_reg(row.reg_sel, row.val);
        default: ;
      endcase
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_SEG_COUNT, 16'd512);
          write_reg(REG_SPEED, 16'h0FFF);
          write_reg(REG_SEG_LENGTH, 16'hFFFF);
          write_reg(REG_ROAD_HEIGHT, 16'h7FFF);
        end
        1: begin
          write_reg(REG_SEG_COUNT, 16'd1);
          write_reg(REG_SPEED, 16'd0);
          write_reg(REG_SEG_LENGTH, 16'd1);
          write_reg(REG_ROAD_HEIGHT, 16'h8000);
        end
        2: begin
          write_reg(REG_SEG_COUNT, 16'd1023);
          write_reg(REG_SPEED, 16'($urandom_range(0, 4095)));
          write_reg(REG_SEG_LENGTH, 16'd0);
          write_reg(REG_ROAD_HEIGHT, 16'($urandom));
        end
        default: begin
          if ($urandom_range(7) == 0)
            write_reg(REG_SEG_COUNT, 16'($urandom_range(0, 1023)));
          else
            write_reg(REG_SEG_COUNT, 16'($urandom_range(2, 200)));
          write_reg(REG_SPEED, 16'($urandom_range(0, 4095)));
          write_reg(REG_SEG_LENGTH, 16'($urandom));
          write_reg(REG_ROAD_HEIGHT, 16'($urandom));
        end
      endcase
      quiet = (ph == RAND_PHASES - 1);
      if (ph == HOLD_PHASE) hold_req = 1'b1;
      phase_end = items_sent + ITEMS_PER_PHASE;
      while (items_sent < phase_end) begin
        if ($urandom_range(9) < 4)
          send_item(p3drpg_pkg::FUNC_WRITE, 9'($urandom), 12'($urandom), 12'($urandom),
                    1'b0, 32'sd0);
        else
          send_tick(1'b0, 32'sd0);
      end
    end

    in_valid <= 1'b0;
    while (road_pts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("pseudo3d_road_point_generator_tb OK");
    else
      $display("pseudo3d_road_point_generator_tb NOT OK");
    $finish;
  end

endmodule

// ----- pseudo3d_road_point_generator.f -----
+incdir+rtl/core
rtl/core/p3drpg_pkg.sv
rtl/core/p3drpg_ram.sv
rtl/core/p3drpg_ctrl.sv
rtl/core/p3drpg_dpath.sv
rtl/core/pseudo3d_road_point_generator.sv
test/pseudo3d_road_point_generator_tb.sv
